// ----- rtl/ssfw_pkg.sv -----
// Shared types, constants and lookup functions for the seven-segment frame writer.
// Used by ssfw_front, ssfw_queue, ssfw_back and seven_segment_frame_writer.
`default_nettype none

package ssfw_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] digit_t;
    typedef logic [1:0] frame_idx_t;

    // Work queue entry: one classified request, ready to be expanded into frames.
    // Number mode: data[0..3] are segment codes, thousands first.
    // Brightness mode: data[0] is the level code, the rest is unused.
    typedef struct packed {
        logic            mode;
        logic            panel;
        logic [3:0][7:0] data;
    } entry_t;

    localparam logic MODE_NUMBER = 1'b0;
    localparam logic MODE_BRIGHT = 1'b1;

    localparam byte_t ADDR_DIGIT0 = 8'h68;
    localparam byte_t ADDR_DIGIT1 = 8'h6A;
    localparam byte_t ADDR_DIGIT2 = 8'h6C;
    localparam byte_t ADDR_DIGIT3 = 8'h6E;
    localparam byte_t ADDR_BRIGHT = 8'h48;

    localparam frame_idx_t LAST_DIGIT_IDX = 2'd3;

    // Reciprocals for divide-by-constant: q = (x * R) >> S
    localparam logic [16:0] RECIP_10K = 17'd107375;   // S = 30, x < 65536
    localparam logic [13:0] RECIP_1K  = 14'd8389;     // S = 23, x < 10000
    localparam logic [5:0]  RECIP_100 = 6'd41;        // S = 12, x < 1000
    localparam logic [7:0]  RECIP_10  = 8'd205;       // S = 11, x < 100

    function automatic byte_t seg_code(input digit_t d);
        byte_t r;
        case (d)
            4'd0:    r = 8'h3f;
            4'd1:    r = 8'h06;
            4'd2:    r = 8'h5b;
            4'd3:    r = 8'h4f;
            4'd4:    r = 8'h66;
            4'd5:    r = 8'h6d;
            4'd6:    r = 8'h7d;
            4'd7:    r = 8'h07;
            4'd8:    r = 8'h7f;
            4'd9:    r = 8'h6f;
            default: r = 8'h3f;
        endcase
        return r;
    endfunction

    function automatic byte_t digit_addr(input frame_idx_t i);
        byte_t r;
        case (i)
            2'd0:    r = ADDR_DIGIT0;
            2'd1:    r = ADDR_DIGIT1;
            2'd2:    r = ADDR_DIGIT2;
            default: r = ADDR_DIGIT3;
        endcase
        return r;
    endfunction

    // Brightness level code; levels below 1 clamp to 1, above 8 clamp to 8.
    function automatic byte_t level_code(input logic [15:0] level);
        logic [2:0] k;
        byte_t      r;
        if (level == 16'd0)
            k = 3'd0;
        else if (level > 16'd8)
            k = 3'd7;
        else
            k = 3'(level - 16'd1);
        case (k)
            3'd0:    r = 8'h11;
            3'd1:    r = 8'h21;
            3'd2:    r = 8'h31;
            3'd3:    r = 8'h41;
            3'd4:    r = 8'h51;
            3'd5:    r = 8'h61;
            3'd6:    r = 8'h71;
            default: r = 8'h01;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] mul_10k(input logic [2:0] q);
        logic [15:0] r;
        case (q)
            3'd0:    r = 16'd0;
            3'd1:    r = 16'd10000;
            3'd2:    r = 16'd20000;
            3'd3:    r = 16'd30000;
            3'd4:    r = 16'd40000;
            3'd5:    r = 16'd50000;
            3'd6:    r = 16'd60000;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic [13:0] mul_1k(input digit_t d);
        logic [13:0] r;
        case (d)
            4'd0:    r = 14'd0;
            4'd1:    r = 14'd1000;
            4'd2:    r = 14'd2000;
            4'd3:    r = 14'd3000;
            4'd4:    r = 14'd4000;
            4'd5:    r = 14'd5000;
            4'd6:    r = 14'd6000;
            4'd7:    r = 14'd7000;
            4'd8:    r = 14'd8000;
            4'd9:    r = 14'd9000;
            default: r = 14'd0;
        endcase
        return r;
    endfunction

    function automatic logic [9:0] mul_100(input digit_t d);
        logic [9:0] r;
        case (d)
            4'd0:    r = 10'd0;
            4'd1:    r = 10'd100;
            4'd2:    r = 10'd200;
            4'd3:    r = 10'd300;
            4'd4:    r = 10'd400;
            4'd5:    r = 10'd500;
            4'd6:    r = 10'd600;
            4'd7:    r = 10'd700;
            4'd8:    r = 10'd800;
            4'd9:    r = 10'd900;
            default: r = 10'd0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] mul_10(input digit_t d);
        logic [6:0] r;
        case (d)
            4'd0:    r = 7'd0;
            4'd1:    r = 7'd10;
            4'd2:    r = 7'd20;
            4'd3:    r = 7'd30;
            4'd4:    r = 7'd40;
            4'd5:    r = 7'd50;
            4'd6:    r = 7'd60;
            4'd7:    r = 7'd70;
            4'd8:    r = 7'd80;
            4'd9:    r = 7'd90;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ssfw_front.sv -----
// Front end: accepts request beats, converts the number to four digits over a
// three-stage pipeline and pushes classified entries into the work queue. Uses ssfw_pkg.
`default_nettype none

module ssfw_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            valid,
    output logic                 stall,
    input  wire logic            mode,
    input  wire logic            panel,
    input  wire logic [15:0]     value,
    input  wire logic            q_full,
    output logic                 push,
    output ssfw_pkg::entry_t     push_entry
);

    // stage 1: value, quotient by 10000, level code
    logic               s1_valid_reg;
    logic               s1_mode_reg;
    logic               s1_panel_reg;
    logic [15:0]        s1_value_reg;
    logic [2:0]         s1_q_reg;
    ssfw_pkg::byte_t    s1_lvl_reg;
    // stage 2: value mod 10000, thousands digit
    logic               s2_valid_reg;
    logic               s2_mode_reg;
    logic               s2_panel_reg;
    ssfw_pkg::byte_t    s2_lvl_reg;
    logic [13:0]        s2_n_reg;
    ssfw_pkg::digit_t   s2_d0_reg;
    // stage 3: remainder below 1000, hundreds digit
    logic               s3_valid_reg;
    logic               s3_mode_reg;
    logic               s3_panel_reg;
    ssfw_pkg::byte_t    s3_lvl_reg;
    ssfw_pkg::digit_t   s3_d0_reg;
    ssfw_pkg::digit_t   s3_d1_reg;
    logic [9:0]         s3_r1_reg;

    logic               rdy1, rdy2, rdy3;
    logic [32:0]        prod1;
    logic [15:0]        n_wide;
    logic [27:0]        prod2;
    logic [13:0]        r1_wide;
    logic [9:0]         r1;
    logic [15:0]        prod3;
    logic [9:0]         r2_wide;
    logic [6:0]         r2;
    logic [14:0]        prod4;
    ssfw_pkg::digit_t   d2;
    logic [6:0]         d3_wide;
    ssfw_pkg::digit_t   d3;

    // a stage moves on when it is empty or the one after it moves on
    assign push  = s3_valid_reg && !q_full;
    assign rdy3  = !s3_valid_reg || !q_full;
    assign rdy2  = !s2_valid_reg || rdy3;
    assign rdy1  = !s1_valid_reg || rdy2;
    assign stall = !rdy1;

    assign prod1   = 33'(value) * 33'(ssfw_pkg::RECIP_10K);
    assign n_wide  = s1_value_reg - ssfw_pkg::mul_10k(s1_q_reg);
    assign prod2   = 28'(n_wide[13:0]) * 28'(ssfw_pkg::RECIP_1K);
    assign r1_wide = s2_n_reg - ssfw_pkg::mul_1k(s2_d0_reg);
    assign r1      = r1_wide[9:0];
    assign prod3   = 16'(r1) * 16'(ssfw_pkg::RECIP_100);
    assign r2_wide = s3_r1_reg - ssfw_pkg::mul_100(s3_d1_reg);
    assign r2      = r2_wide[6:0];
    assign prod4   = 15'(r2) * 15'(ssfw_pkg::RECIP_10);
    assign d2      = prod4[14:11];
    assign d3_wide = r2 - ssfw_pkg::mul_10(d2);
    assign d3      = d3_wide[3:0];

    always_comb
    begin
        push_entry.mode  = s3_mode_reg;
        push_entry.panel = s3_panel_reg;
        push_entry.data[0] = (s3_mode_reg == ssfw_pkg::MODE_BRIGHT) ?
                             s3_lvl_reg : ssfw_pkg::seg_code(s3_d0_reg);
        push_entry.data[1] = ssfw_pkg::seg_code(s3_d1_reg);
        push_entry.data[2] = ssfw_pkg::seg_code(d2);
        push_entry.data[3] = ssfw_pkg::seg_code(d3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= valid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && valid)
        begin
            s1_mode_reg  <= mode;
            s1_panel_reg <= panel;
            s1_value_reg <= value;
            s1_q_reg     <= prod1[32:30];
            s1_lvl_reg   <= ssfw_pkg::level_code(value);
        end
        if (rdy2 && s1_valid_reg)
        begin
            s2_mode_reg  <= s1_mode_reg;
            s2_panel_reg <= s1_panel_reg;
            s2_lvl_reg   <= s1_lvl_reg;
            s2_n_reg     <= n_wide[13:0];
            s2_d0_reg    <= prod2[26:23];
        end
        if (rdy3 && s2_valid_reg)
        begin
            s3_mode_reg  <= s2_mode_reg;
            s3_panel_reg <= s2_panel_reg;
            s3_lvl_reg   <= s2_lvl_reg;
            s3_d0_reg    <= s2_d0_reg;
            s3_d1_reg    <= prod3[15:12];
            s3_r1_reg    <= r1;
        end
    end

`ifndef SYNTHESIS
    // input is held off only when every stage is occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && q_full))
        else $error("front stalls with a free stage");
`endif

endmodule

`default_nettype wire

// ----- rtl/ssfw_queue.sv -----
// Short work queue between front end and frame sequencer.
// Holds ssfw_pkg::entry_t entries; depth set by DEPTH.
`default_nettype none

module ssfw_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ssfw_pkg::entry_t  push_entry,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output ssfw_pkg::entry_t       head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ssfw_pkg::entry_t   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && !not_empty))
        else $error("queue overflow or underflow");
`endif

endmodule

`default_nettype wire

// ----- rtl/ssfw_back.sv -----
// Back end: expands queue entries into register-write frames, one per cycle while frame_stall is low,
// into an output register. Uses ssfw_pkg.
`default_nettype none

module ssfw_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_not_empty,
    input  wire ssfw_pkg::entry_t  head,
    output logic                   pop,
    output logic                   frame_valid,
    input  wire logic              frame_stall,
    output logic                   panel_out,
    output ssfw_pkg::byte_t        reg_address,
    output ssfw_pkg::byte_t        reg_data,
    output logic                   last
);

    logic                   out_valid_reg;
    logic                   panel_reg;
    ssfw_pkg::byte_t        addr_reg;
    ssfw_pkg::byte_t        data_reg;
    logic                   last_reg;
    ssfw_pkg::frame_idx_t   idx_reg, idx_next;

    logic                   load;
    logic                   emit;
    logic                   is_bright;
    logic                   final_frame;

    assign load        = !out_valid_reg || !frame_stall;
    assign emit        = load && q_not_empty;
    assign is_bright   = (head.mode == ssfw_pkg::MODE_BRIGHT);
    assign final_frame = is_bright || (idx_reg == ssfw_pkg::LAST_DIGIT_IDX);
    assign pop         = emit && final_frame;

    always_comb
    begin
        idx_next = idx_reg;
        if (emit)
            idx_next = final_frame ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
                out_valid_reg <= q_not_empty;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            panel_reg <= head.panel;
            addr_reg  <= is_bright ? ssfw_pkg::ADDR_BRIGHT : ssfw_pkg::digit_addr(idx_reg);
            data_reg  <= is_bright ? head.data[0] : head.data[idx_reg];
            last_reg  <= final_frame;
        end
    end

    assign frame_valid = out_valid_reg;
    assign panel_out   = panel_reg;
    assign reg_address = addr_reg;
    assign reg_data    = data_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    // mid-number position only while a number entry sits at the head
    a_idx_head: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> (q_not_empty && head.mode == ssfw_pkg::MODE_NUMBER))
        else $error("frame index advanced without a number entry");

    a_last_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_reg == (addr_reg == ssfw_pkg::ADDR_DIGIT3
                                        || addr_reg == ssfw_pkg::ADDR_BRIGHT)))
        else $error("last flag does not match frame address");
`endif

endmodule

`default_nettype wire

// ----- rtl/seven_segment_frame_writer.sv -----
// Top level of the seven-segment frame writer.
// Instantiates ssfw_front, ssfw_queue and ssfw_back; uses ssfw_pkg.
//
// Usage:
//   Request channel (valid/stall; mode, panel, value): one beat per request.
//     mode 0 shows value mod 10000 on the panel as four digits; mode 1 sets
//     brightness, value clamped to 1..8.
//   Frame channel (frame_valid/frame_stall; panel_out, reg_address, reg_data,
//     last): a number request yields four beats to digit registers 0x68,
//     0x6A, 0x6C, 0x6E (thousands first); a brightness request yields one beat
//     to 0x48. last marks the final beat of each request.
//   Path: a request passes stages 1 to 3, the work queue and the output register.
//   Throughput: one frame per cycle while frame_stall is low, set by the frame
//     sequencer; a number request yields four frames, a brightness request one.
//     Requests are taken on back-to-back cycles while the work queue has room.
//   Stall: frame_stall holds the output register; the sequencer and queue
//     fill, then the three-stage digit pipeline, then stall goes high.
//   Reset: rst_n (async, active low) empties pipeline, queue and output;
//     no clearing pass is needed.
`default_nettype none

module seven_segment_frame_writer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             stall,
    input  wire logic        mode,
    input  wire logic        panel,
    input  wire logic [15:0] value,
    output logic             frame_valid,
    input  wire logic        frame_stall,
    output logic             panel_out,
    output logic [7:0]       reg_address,
    output logic [7:0]       reg_data,
    output logic             last
);

    logic               push;
    ssfw_pkg::entry_t   push_entry;
    logic               q_full;
    logic               q_not_empty;
    logic               pop;
    ssfw_pkg::entry_t   head;

    // digit conversion and classification
    ssfw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (valid),
        .stall      (stall),
        .mode       (mode),
        .panel      (panel),
        .value      (value),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouples conversion from frame output
    ssfw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    // one frame beat per cycle while frame_stall is low
    ssfw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .panel_out   (panel_out),
        .reg_address (reg_address),
        .reg_data    (reg_data),
        .last        (last)
    );

endmodule

`default_nettype wire
